FILE: rtl/pair_dispersion_accumulator_defines.svh
// Assertion macros for the pair dispersion accumulator checker.
// No dependencies; included by the checker file only.
`ifndef PAIR_DISPERSION_ACCUMULATOR_DEFINES_SVH
`define PAIR_DISPERSION_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PDA_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("pda check failed");

// Next-cycle implication, disabled while reset is asserted
`define PDA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("pda check failed");

`endif

FILE: rtl/pda_pkg.sv
// Shared widths, register codes, stream field offsets and the frame record type
// for the pair dispersion accumulator. No dependencies.
package pda_pkg;

	// Field widths
	localparam int PosW     = 24;
	localparam int ZW       = 21;
	localparam int BoxW     = 24;
	localparam int StepW    = 24;
	localparam int TimeW    = 32;
	localparam int ScaledW  = 56;
	localparam int CntW     = 13;
	localparam int SumXyzW  = 60;
	localparam int SumXyW   = 59;
	localparam int SumZW    = 54;
	localparam int MeanXyzW = 48;
	localparam int MeanXyW  = 47;
	localparam int MeanZW   = 43;

	// Wrapped separation is at most half the box
	localparam int SepW  = PosW - 1;
	localparam int SqXW  = 2 * SepW;
	localparam int SqXyW = 2 * SepW + 1;
	localparam int SqZW  = 2 * ZW;

	localparam int MaxPairs      = 4096;
	localparam int QueueDepthDef = 4;

	// Configuration port
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 24;
	localparam logic [CfgIdxW-1:0] CfgBoxX     = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgBoxY     = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgTimeStep = 2'd2;

	// Stream layouts
	localparam int InDataW     = 176;
	localparam int InUserW     = 2;
	localparam int InXFirstLo  = 0;
	localparam int InYFirstLo  = 24;
	localparam int InZFirstLo  = 48;
	localparam int InXSecondLo = 69;
	localparam int InYSecondLo = 93;
	localparam int InZSecondLo = 117;
	localparam int InTimeLo    = 138;
	localparam int UserUsable  = 0;
	localparam int UserMissing = 1;

	localparam int OutDataW   = 208;
	localparam int OutCountLo = ScaledW;

	// One finished frame handed from front to back
	typedef struct packed {
		logic [SumXyzW-1:0] sum_xyz;
		logic [SumXyW-1:0]  sum_xy;
		logic [SumZW-1:0]   sum_z;
		logic [CntW-1:0]    count;
		logic [TimeW-1:0]   frame_time;
	} frame_rec_t;

endpackage

FILE: rtl/pair_dispersion_accumulator.sv
// Channel     Dir  Handshake                      Payload
// s_axis      in   s_axis_tvalid/s_axis_tready    tdata pair positions+time, tuser flags, tlast
// m_axis      out  m_axis_tvalid/m_axis_tready    tdata frame result
// cfg         in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// Pairs are taken one per cycle into a four-stage wrap/square/accumulate pipeline.
// Each non-empty frame end then passes the back part: a load, the steps of
// the bit-serial divider (one quotient bit per step for all three sums) and one output load.
// Up to QUEUE_DEPTH finished frames wait between the two; s_axis_tready drops while the queue
// and the frame ends still in the pipeline would fill it. A held result stalls the back only.
// Reset is asynchronous and takes effect at once; there is no clearing pass.
//
// Top level of the pair dispersion accumulator: configuration registers and stream packing.
// Depends on pda_pkg, pda_front, pda_frame_queue and pda_back.
module pair_dispersion_accumulator import pda_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// x_first, y_first, z_first, x_second, y_second, z_second, frame_time, zero pad
	input  logic [InDataW-1:0]   s_axis_tdata,
	// pair_usable, position_missing
	input  logic [InUserW-1:0]   s_axis_tuser,
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// scaled_time, pair_count, mean_r2_xyz, mean_r2_xy, mean_r2_z, zero pad
	output logic [OutDataW-1:0]  m_axis_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	localparam int LvlW = $clog2(QUEUE_DEPTH + 1);

	logic [BoxW-1:0]       box_x_q, box_y_q;
	logic [StepW-1:0]      time_step_q;

	logic                  q_push, q_pop, q_empty;
	frame_rec_t            q_push_rec, q_pop_rec;
	logic [LvlW-1:0]       q_level;

	logic [ScaledW-1:0]    scaled_time;
	logic [CntW-1:0]       pair_count;
	logic [MeanXyzW-1:0]   mean_r2_xyz;
	logic [MeanXyW-1:0]    mean_r2_xy;
	logic [MeanZW-1:0]     mean_r2_z;

	// Configuration registers; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= BoxW'(65536);
			box_y_q <= BoxW'(65536);
			time_step_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgBoxX:     box_x_q <= cfg_data;
				CfgBoxY:     box_y_q <= cfg_data;
				CfgTimeStep: time_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pda_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.box_x            (box_x_q),
		.box_y            (box_y_q),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.x_first          (s_axis_tdata[InXFirstLo +: PosW]),
		.y_first          (s_axis_tdata[InYFirstLo +: PosW]),
		.z_first          (s_axis_tdata[InZFirstLo +: ZW]),
		.x_second         (s_axis_tdata[InXSecondLo +: PosW]),
		.y_second         (s_axis_tdata[InYSecondLo +: PosW]),
		.z_second         (s_axis_tdata[InZSecondLo +: ZW]),
		.pair_usable      (s_axis_tuser[UserUsable]),
		.position_missing (s_axis_tuser[UserMissing]),
		.last_in_frame    (s_axis_tlast),
		.frame_time       (s_axis_tdata[InTimeLo +: TimeW]),
		.q_level          (q_level),
		.push             (q_push),
		.push_rec         (q_push_rec)
	);

	pda_frame_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_push_rec),
		.pop      (q_pop),
		.pop_rec  (q_pop_rec),
		.empty    (q_empty),
		.level    (q_level)
	);

	pda_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.time_step   (time_step_q),
		.rec         (q_pop_rec),
		.empty       (q_empty),
		.pop         (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.scaled_time (scaled_time),
		.pair_count  (pair_count),
		.mean_r2_xyz (mean_r2_xyz),
		.mean_r2_xy  (mean_r2_xy),
		.mean_r2_z   (mean_r2_z)
	);

	// Result packing, first field lowest
	assign m_axis_tdata = {1'b0, mean_r2_z, mean_r2_xy, mean_r2_xyz, pair_count, scaled_time};

endmodule

FILE: rtl/pda_front.sv
// Front part: accepts pairs, classifies them, wraps, squares and accumulates,
// and pushes one frame record per non-empty frame. Depends on pda_pkg.
module pda_front import pda_pkg::*; #(
	parameter int DEPTH = QueueDepthDef
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [BoxW-1:0]                     box_x,
	input  logic [BoxW-1:0]                     box_y,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [PosW-1:0]                     x_first,
	input  logic [PosW-1:0]                     y_first,
	input  logic signed [ZW-1:0]                z_first,
	input  logic [PosW-1:0]                     x_second,
	input  logic [PosW-1:0]                     y_second,
	input  logic signed [ZW-1:0]                z_second,
	input  logic                                pair_usable,
	input  logic                                position_missing,
	input  logic                                last_in_frame,
	input  logic [TimeW-1:0]                    frame_time,
	input  logic [$clog2(DEPTH+1)-1:0]          q_level,
	output logic                                push,
	output frame_rec_t                          push_rec
);

	localparam int LvlW  = $clog2(DEPTH + 1);
	localparam int OccW  = LvlW + 3;

	// Minimum-image wrap of a raw separation already known to be at most twice the box
	function automatic logic [SepW-1:0] wrap_sep(input logic [PosW-1:0] d,
			input logic [BoxW-1:0] box);
		logic [PosW-1:0] d1;
		logic [PosW-1:0] d2;
		d1 = (d > box) ? (d - box) : d;
		d2 = ({d1, 1'b0} > {1'b0, box}) ? (box - d1) : d1;
		return d2[SepW-1:0];
	endfunction

	logic                  halted_q;
	logic [CntW-1:0]       cnt_q;

	logic                  accept;
	logic [PosW-1:0]       dx_raw, dy_raw;
	logic signed [ZW:0]    dz_full;
	logic [ZW-1:0]         dz_mag;
	logic                  bad_x, bad_y, take0, last_eff;
	logic [CntW-1:0]       cnt_next;

	logic                  take_s1, take_s2, take_s3;
	logic                  push_s1, push_s2, push_s3, push_s4;
	logic [PosW-1:0]       dx_s1, dy_s1;
	logic [ZW-1:0]         dz_s1, dz_s2;
	logic [SepW-1:0]       dx_s2, dy_s2;
	logic [SqXW-1:0]       sqx_s3, sqy_s3;
	logic [SqZW-1:0]       sqz_s3, sz_s4;
	logic [SqXyW-1:0]      sxy_s4;
	logic [CntW-1:0]       cnt_s1, cnt_s2, cnt_s3, cnt_s4;
	logic [TimeW-1:0]      time_s1, time_s2, time_s3, time_s4;

	logic [SumXyzW-1:0]    sum_xyz_q, nx_xyz;
	logic [SumXyW-1:0]     sum_xy_q, nx_xy;
	logic [SumZW-1:0]      sum_z_q, nx_z;
	logic [2:0]            pend;
	logic [OccW-1:0]       occ;

	// Credit check: queued frames plus frame ends still in the pipeline
	assign pend = 3'(push_s1) + 3'(push_s2) + 3'(push_s3) + 3'(push_s4);
	assign occ = OccW'(q_level) + OccW'(pend);
	assign in_ready = occ < OccW'(DEPTH);
	assign accept = in_valid && in_ready;

	// Classification on the incoming pair
	always_comb begin
		dx_raw = (x_first >= x_second) ? (x_first - x_second) : (x_second - x_first);
		dy_raw = (y_first >= y_second) ? (y_first - y_second) : (y_second - y_first);
		bad_x = {1'b0, dx_raw} > {box_x, 1'b0};
		bad_y = {1'b0, dy_raw} > {box_y, 1'b0};
		dz_full = (ZW+1)'(z_first) - (ZW+1)'(z_second);
		dz_mag = dz_full[ZW] ? ZW'(-dz_full) : dz_full[ZW-1:0];
		take0 = !halted_q && pair_usable && !position_missing && !bad_x && !bad_y
			&& (cnt_q < CntW'(MaxPairs));
		cnt_next = cnt_q + CntW'(take0);
		last_eff = last_in_frame && !halted_q;
	end

	// Pair count and halt flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
			cnt_q <= '0;
		end else if (accept) begin
			if (last_eff) begin
				cnt_q <= '0;
				if (cnt_next == '0)
					halted_q <= 1'b1;
			end else begin
				cnt_q <= cnt_next;
			end
		end
	end

	// Stage control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1 <= 1'b0;
			take_s2 <= 1'b0;
			take_s3 <= 1'b0;
			push_s1 <= 1'b0;
			push_s2 <= 1'b0;
			push_s3 <= 1'b0;
			push_s4 <= 1'b0;
		end else begin
			take_s1 <= accept && take0;
			push_s1 <= accept && last_eff && (cnt_next != '0);
			take_s2 <= take_s1;
			take_s3 <= take_s2;
			push_s2 <= push_s1;
			push_s3 <= push_s2;
			push_s4 <= push_s3;
		end
	end

	// Payload pipeline: raw separations, wrap, squares, pre-add
	always_ff @(posedge clk) begin
		dx_s1 <= dx_raw;
		dy_s1 <= dy_raw;
		dz_s1 <= dz_mag;
		cnt_s1 <= cnt_next;
		time_s1 <= frame_time;

		dx_s2 <= wrap_sep(dx_s1, box_x);
		dy_s2 <= wrap_sep(dy_s1, box_y);
		dz_s2 <= dz_s1;
		cnt_s2 <= cnt_s1;
		time_s2 <= time_s1;

		sqx_s3 <= SqXW'(dx_s2) * SqXW'(dx_s2);
		sqy_s3 <= SqXW'(dy_s2) * SqXW'(dy_s2);
		sqz_s3 <= SqZW'(dz_s2) * SqZW'(dz_s2);
		cnt_s3 <= cnt_s2;
		time_s3 <= time_s2;

		sxy_s4 <= take_s3 ? (SqXyW'(sqx_s3) + SqXyW'(sqy_s3)) : '0;
		sz_s4 <= take_s3 ? sqz_s3 : '0;
		cnt_s4 <= cnt_s3;
		time_s4 <= time_s3;
	end

	// Accumulation; a frame end hands the totals over and clears them
	assign nx_xyz = sum_xyz_q + SumXyzW'(sxy_s4) + SumXyzW'(sz_s4);
	assign nx_xy = sum_xy_q + SumXyW'(sxy_s4);
	assign nx_z = sum_z_q + SumZW'(sz_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_xyz_q <= '0;
			sum_xy_q <= '0;
			sum_z_q <= '0;
		end else if (push_s4) begin
			sum_xyz_q <= '0;
			sum_xy_q <= '0;
			sum_z_q <= '0;
		end else begin
			sum_xyz_q <= nx_xyz;
			sum_xy_q <= nx_xy;
			sum_z_q <= nx_z;
		end
	end

	assign push = push_s4;
	assign push_rec = '{sum_xyz: nx_xyz, sum_xy: nx_xy, sum_z: nx_z,
		count: cnt_s4, frame_time: time_s4};

endmodule

FILE: rtl/pda_frame_queue.sv
// Short queue of finished frame records between front and back.
// Depends on pda_pkg.
module pda_frame_queue import pda_pkg::*; #(
	parameter int DEPTH = QueueDepthDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  frame_rec_t                    push_rec,
	input  logic                          pop,
	output frame_rec_t                    pop_rec,
	output logic                          empty,
	output logic [$clog2(DEPTH+1)-1:0]    level
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LvlW = $clog2(DEPTH + 1);

	frame_rec_t            mem_q [DEPTH];
	logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [LvlW-1:0]       level_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : (p + 1'b1);
	endfunction

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				level_q <= level_q + 1'b1;
			else if (pop && !push)
				level_q <= level_q - 1'b1;
		end
	end

	assign pop_rec = mem_q[rd_ptr_q];
	assign empty = (level_q == '0);
	assign level = level_q;

endmodule

FILE: rtl/pda_back.sv
// Back part: takes frame records, scales the time, divides the three sums by
// the pair count one quotient bit a cycle, and holds the result. Depends on pda_pkg.
module pda_back import pda_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [StepW-1:0]     time_step,
	input  frame_rec_t           rec,
	input  logic                 empty,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ScaledW-1:0]   scaled_time,
	output logic [CntW-1:0]      pair_count,
	output logic [MeanXyzW-1:0]  mean_r2_xyz,
	output logic [MeanXyW-1:0]   mean_r2_xy,
	output logic [MeanZW-1:0]    mean_r2_z
);

	localparam int Lanes  = 3;
	localparam int StepsW = $clog2(SumXyzW);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} back_state_t;

	back_state_t           state_q;
	logic [StepsW-1:0]     step_q;
	logic                  out_valid_q;

	logic [SumXyzW-1:0]    quo_q [Lanes];
	logic [CntW-1:0]       rem_q [Lanes];
	logic [SumXyzW-1:0]    quo_nx [Lanes];
	logic [CntW-1:0]       rem_nx [Lanes];
	logic [CntW-1:0]       div_q;
	logic [CntW-1:0]       cnt_q;
	logic [ScaledW-1:0]    scaled_q;

	logic [ScaledW-1:0]    scaled_o_q;
	logic [CntW-1:0]       count_o_q;
	logic [MeanXyzW-1:0]   xyz_o_q;
	logic [MeanXyW-1:0]    xy_o_q;
	logic [MeanZW-1:0]     z_o_q;

	// One restoring division step per lane
	always_comb begin
		logic [CntW:0] trial;
		for (int i = 0; i < Lanes; i++) begin
			trial = {rem_q[i], quo_q[i][SumXyzW-1]};
			if (trial >= {1'b0, div_q}) begin
				rem_nx[i] = CntW'(trial - {1'b0, div_q});
				quo_nx[i] = {quo_q[i][SumXyzW-2:0], 1'b1};
			end else begin
				rem_nx[i] = trial[CntW-1:0];
				quo_nx[i] = {quo_q[i][SumXyzW-2:0], 1'b0};
			end
		end
	end

	assign pop = (state_q == ST_IDLE) && !empty;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (!empty)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == StepsW'(SumXyzW - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		if (pop) begin
			quo_q[0] <= rec.sum_xyz;
			quo_q[1] <= SumXyzW'(rec.sum_xy);
			quo_q[2] <= SumXyzW'(rec.sum_z);
			for (int i = 0; i < Lanes; i++)
				rem_q[i] <= '0;
			div_q <= rec.count;
			cnt_q <= rec.count;
			scaled_q <= ScaledW'(time_step) * ScaledW'(rec.frame_time);
		end else if (state_q == ST_DIV) begin
			for (int i = 0; i < Lanes; i++) begin
				quo_q[i] <= quo_nx[i];
				rem_q[i] <= rem_nx[i];
			end
		end
		if ((state_q == ST_DONE) && !out_valid_q) begin
			scaled_o_q <= scaled_q;
			count_o_q <= cnt_q;
			xyz_o_q <= quo_q[0][MeanXyzW-1:0];
			xy_o_q <= quo_q[1][MeanXyW-1:0];
			z_o_q <= quo_q[2][MeanZW-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign scaled_time = scaled_o_q;
	assign pair_count = count_o_q;
	assign mean_r2_xyz = xyz_o_q;
	assign mean_r2_xy = xy_o_q;
	assign mean_r2_z = z_o_q;

endmodule

FILE: rtl/pda_checker.sv
// Port-level checks for the pair dispersion accumulator, bound to the top level.
// Depends on pda_pkg and pair_dispersion_accumulator_defines.svh.
`include "pair_dispersion_accumulator_defines.svh"

module pda_checker import pda_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [OutDataW-1:0]  m_axis_tdata,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	logic [CntW-1:0] out_count;
	assign out_count = m_axis_tdata[OutCountLo +: CntW];

	// A result always carries a count within the frame limit
	`PDA_ASSERT_NOW(a_count_range, clk, arst_n, m_axis_tvalid, (out_count != '0) && (out_count <= CntW'(MaxPairs)))

	// A stalled result holds
	`PDA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// Results are never back to back: each frame must pass through the bit-serial divider first
	`PDA_ASSERT_NEXT(a_out_gap, clk, arst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)

	// Configuration writes are never refused
	`PDA_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind pair_dispersion_accumulator pda_checker u_pda_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);

FILE: bench/tb_pair_dispersion_accumulator.sv
// Self-checking bench for the pair dispersion accumulator: streams particle pairs,
// predicts each frame's count and mean squared separations, and checks every result.
// Depends on pda_pkg and pair_dispersion_accumulator.
`timescale 1ns / 100ps

module tb_pair_dispersion_accumulator import pda_pkg::*; ();

	localparam int IdlePct        = 29;
	localparam int SettleCycles   = 100;
	localparam int EndCycles      = 200;
	localparam int WatchdogLimit  = 4000;
	localparam int PhaseItems     = 280;

	localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

	localparam logic signed [ZW-1:0] ZMin = {1'b1, {(ZW-1){1'b0}}};
	localparam logic signed [ZW-1:0] ZMax = {1'b0, {(ZW-1){1'b1}}};
	localparam logic [PosW-1:0]      PosMax = {PosW{1'b1}};

	localparam int MeanXyzLo = OutCountLo + CntW;
	localparam int MeanXyLo  = MeanXyzLo + MeanXyzW;
	localparam int MeanZLo   = MeanXyLo + MeanXyW;

	typedef struct {
		logic [PosW-1:0]        x0;
		logic [PosW-1:0]        y0;
		logic signed [ZW-1:0]   z0;
		logic [PosW-1:0]        x1;
		logic [PosW-1:0]        y1;
		logic signed [ZW-1:0]   z1;
		bit                     usable;
		bit                     missing;
		bit                     last;
		logic [TimeW-1:0]       frame_time;
	} pair_item_t;

	typedef struct packed {
		logic [ScaledW-1:0]  scaled_time;
		logic [CntW-1:0]     pair_count;
		logic [MeanXyzW-1:0] mean_xyz;
		logic [MeanXyW-1:0]  mean_xy;
		logic [MeanZW-1:0]   mean_z;
	} frame_result_t;

	// Frame accumulator mirror: running sums, pair count and the queue of frame results
	class dispersion_board;
		logic [BoxW-1:0]    box_x;
		logic [BoxW-1:0]    box_y;
		logic [StepW-1:0]   time_step;
		logic [SumXyzW-1:0] sum_xyz;
		logic [SumXyW-1:0]  sum_xy;
		logic [SumZW-1:0]   sum_z;
		int unsigned        frame_pairs;
		bit                 halted;
		frame_result_t      pending_frames[$];
		int unsigned        mismatch_count;

		function new();
			box_x = 24'd65536;
			box_y = 24'd65536;
			time_step = '0;
			sum_xyz = '0;
			sum_xy = '0;
			sum_z = '0;
			frame_pairs = 0;
			halted = 1'b0;
			mismatch_count = 0;
		endfunction

		function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			case (idx)
				CfgBoxX:     box_x = val;
				CfgBoxY:     box_y = val;
				CfgTimeStep: time_step = val;
				default: ;
			endcase
		endfunction

		// Minimum-image separation; 0 when the raw distance exceeds twice the box
		static function bit min_image(logic [PosW-1:0] a, logic [PosW-1:0] b,
				logic [BoxW-1:0] box, output logic [PosW-1:0] sep);
			logic [PosW-1:0] d;
			d = (a > b) ? a - b : b - a;
			if ({1'b0, d} > {box, 1'b0})
				return 1'b0;
			if (d > box)
				d = d - box;
			if ({d, 1'b0} > {1'b0, box})
				d = box - d;
			sep = d;
			return 1'b1;
		endfunction

		function bit pair_counts(pair_item_t p);
			logic [PosW-1:0] dx;
			logic [PosW-1:0] dy;
			return !halted && p.usable && !p.missing && min_image(p.x0, p.x1, box_x, dx) &&
				min_image(p.y0, p.y1, box_y, dy) && frame_pairs < MaxPairs;
		endfunction

		// Accumulate one accepted pair; a frame end queues the frame's result
		function void take_pair(pair_item_t p);
			logic [PosW-1:0]      dx;
			logic [PosW-1:0]      dy;
			logic signed [ZW:0]   dz;
			logic [63:0]          dz_mag;
			logic [63:0]          sq_xy;
			logic [63:0]          sq_z;
			frame_result_t        r;
			if (halted)
				return;
			if (p.usable && !p.missing && min_image(p.x0, p.x1, box_x, dx) &&
					min_image(p.y0, p.y1, box_y, dy) && frame_pairs < MaxPairs) begin
				dz = p.z0 - p.z1;
				dz_mag = (dz < 0) ? 64'(-dz) : 64'(dz);
				sq_xy = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
				sq_z = dz_mag * dz_mag;
				sum_xyz = SumXyzW'(sum_xyz + sq_xy + sq_z);
				sum_xy = SumXyW'(sum_xy + sq_xy);
				sum_z = SumZW'(sum_z + sq_z);
				frame_pairs++;
			end
			if (!p.last)
				return;
			// an empty frame stops all output until reset
			if (frame_pairs == 0) begin
				halted = 1'b1;
				return;
			end
			r.scaled_time = time_step * p.frame_time;
			r.pair_count = CntW'(frame_pairs);
			r.mean_xyz = MeanXyzW'(sum_xyz / frame_pairs);
			r.mean_xy = MeanXyW'(sum_xy / frame_pairs);
			r.mean_z = MeanZW'(sum_z / frame_pairs);
			pending_frames = {pending_frames, r};
			sum_xyz = '0;
			sum_xy = '0;
			sum_z = '0;
			frame_pairs = 0;
		endfunction

		task flag_mismatch(string what);
			$display("mismatch at %0t ns: %s", $time, what);
			mismatch_count++;
		endtask

		task compare_frame(logic [OutDataW-1:0] d);
			frame_result_t got;
			frame_result_t want;
			got.scaled_time = d[0 +: ScaledW];
			got.pair_count = d[OutCountLo +: CntW];
			got.mean_xyz = d[MeanXyzLo +: MeanXyzW];
			got.mean_xy = d[MeanXyLo +: MeanXyW];
			got.mean_z = d[MeanZLo +: MeanZW];
			if (pending_frames.size() == 0) begin
				flag_mismatch($sformatf("result with no frame pending, count %0d",
					got.pair_count));
				return;
			end
			want = pending_frames.pop_front();
			if (got.scaled_time !== want.scaled_time)
				flag_mismatch($sformatf("scaled_time %h, predicted %h",
					got.scaled_time, want.scaled_time));
			if (got.pair_count !== want.pair_count)
				flag_mismatch($sformatf("pair_count %0d, predicted %0d",
					got.pair_count, want.pair_count));
			if (got.mean_xyz !== want.mean_xyz)
				flag_mismatch($sformatf("mean_r2_xyz %h, predicted %h",
					got.mean_xyz, want.mean_xyz));
			if (got.mean_xy !== want.mean_xy)
				flag_mismatch($sformatf("mean_r2_xy %h, predicted %h",
					got.mean_xy, want.mean_xy));
			if (got.mean_z !== want.mean_z)
				flag_mismatch($sformatf("mean_r2_z %h, predicted %h",
					got.mean_z, want.mean_z));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata;
	logic [InUserW-1:0]  s_axis_tuser;
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	dispersion_board sb;
	bit              steady;
	int unsigned     quiet_cycles;

	pair_dispersion_accumulator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < IdlePct);
	endfunction

	// Result side back-pressure
	always @(posedge clk) begin
		m_axis_tready <= !take_break();
	end

	// Handshakes are sampled mid-cycle, where every signal is settled
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.compare_frame(m_axis_tdata);
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WatchdogLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic pair_item_t make_pair(input logic [PosW-1:0] x0, y0,
			input logic signed [ZW-1:0] z0, input logic [PosW-1:0] x1, y1,
			input logic signed [ZW-1:0] z1, input bit usable, missing, last,
			input logic [TimeW-1:0] ft);
		pair_item_t p;
		p.x0 = x0;
		p.y0 = y0;
		p.z0 = z0;
		p.x1 = x1;
		p.y1 = y1;
		p.z1 = z1;
		p.usable = usable;
		p.missing = missing;
		p.last = last;
		p.frame_time = ft;
		return p;
	endfunction

	// Partner coordinate: mostly within twice the box, so the wrap branches and the
	// invalid boundary are all reached
	function automatic logic [PosW-1:0] near_coord(input logic [PosW-1:0] a,
			input logic [BoxW-1:0] box);
		logic [31:0] off;
		logic [31:0] up;
		case ($urandom_range(7))
			0: return PosW'($urandom);
			1: return a;
			2: off = 2 * box;
			3: off = 2 * box + 1;
			default: off = $urandom_range(2 * box + 2);
		endcase
		up = a + off;
		if (up <= 32'hFFFFFF)
			return up[PosW-1:0];
		if (a >= off)
			return PosW'(a - off);
		return PosW'($urandom);
	endfunction

	function automatic pair_item_t random_pair();
		pair_item_t p;
		p.x0 = PosW'($urandom);
		p.y0 = PosW'($urandom);
		p.x1 = near_coord(p.x0, sb.box_x);
		p.y1 = near_coord(p.y0, sb.box_y);
		p.z0 = ZW'($urandom);
		p.z1 = ($urandom_range(3) == 0) ? ZW'($urandom) : p.z0 + ZW'($urandom_range(4095));
		p.usable = $urandom_range(19) != 0;
		p.missing = $urandom_range(15) == 0;
		p.last = $urandom_range(7) == 0;
		p.frame_time = $urandom;
		return p;
	endfunction

	// One pair transfer with random gaps in front of it
	task automatic send_pair(input pair_item_t p);
		bit got;
		while (take_break()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(InDataW - InTimeLo - TimeW){1'b0}}, p.frame_time, p.z1, p.y1,
			p.x1, p.z0, p.y0, p.x0};
		s_axis_tuser <= {p.missing, p.usable};
		s_axis_tlast <= p.last;
		do begin
			@(negedge clk);
			got = s_axis_tready;
			@(posedge clk);
		end while (!got);
		sb.take_pair(p);
	endtask

	// Stop the pair stream and wait until every pending frame result is back
	task automatic hold_sender();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_frames.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CfgIdxW-1:0] idx,
			input logic [CfgDataW-1:0] val);
		bit got;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			got = cfg_ready;
			@(posedge clk);
		end while (!got);
		sb.set_register(idx, val);
	endtask

	// Registers change only once the block has drained and settled
	task automatic configure(input logic [BoxW-1:0] bx, input logic [BoxW-1:0] by,
			input logic [StepW-1:0] ts);
		hold_sender();
		repeat (SettleCycles) @(posedge clk);
		write_register(CfgBoxX, bx);
		write_register(CfgBoxY, by);
		write_register(CfgTimeStep, ts);
		// unmapped index, must leave everything unchanged
		write_register(CfgUnused, CfgDataW'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int unsigned items, input int unsigned drain_at);
		pair_item_t p;
		for (int unsigned k = 0; k < items; k++) begin
			if (k == drain_at)
				hold_sender();
			p = random_pair();
			// keep frames non-empty; an empty frame would silence the block for good
			if (p.last && sb.frame_pairs == 0 && !sb.pair_counts(p))
				p.last = 1'b0;
			send_pair(p);
		end
	endtask

	initial begin
		pair_item_t p;
		sb = new();
		steady = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: unit box, zero time step
		send_pair(make_pair(0, 0, ZMin, 0, 0, ZMax, 1, 0, 0, 0));
		send_pair(make_pair(0, 24'h008001, 0, 24'h018000, 0, 0, 1, 0, 0, 0));
		send_pair(make_pair(24'h020000, 24'h123456, 5, 0, 24'h123456, -5, 1, 0, 0, 0));
		send_pair(make_pair(0, 0, 0, 24'h020001, 0, 0, 1, 0, 0, 0));
		send_pair(make_pair(1, 2, 3, 4, 5, 6, 0, 0, 0, 0));
		send_pair(make_pair(1, 2, 3, 4, 5, 6, 1, 1, 0, 0));
		send_pair(make_pair(0, PosMax, 0, 0, 0, 0, 1, 0, 1, 32'hFFFFFFFF));
		send_pair(make_pair(PosMax, PosMax, ZMax, PosMax, PosMax, ZMax, 1, 0, 0, 0));
		// frame closed by a skipped pair
		send_pair(make_pair(7, 7, 7, 9, 9, 9, 0, 0, 1, 32'h5A5A5A5A));

		// Largest box and time step
		configure(PosMax, PosMax, {StepW{1'b1}});
		send_pair(make_pair(0, 0, ZMax, PosMax, 24'h800000, ZMin, 1, 0, 0, 0));
		send_pair(make_pair(PosMax, 24'h7FFFFF, ZMin, 24'h7FFFFF, PosMax, ZMin, 1, 0, 0, 0));
		send_pair(make_pair(1, 0, 0, 0, 0, 0, 1, 0, 1, 32'hFFFFFFFF));

		// Zero box: only coincident x and y pass
		configure(0, 0, 24'd1);
		send_pair(make_pair(24'h555555, 24'hAAAAAA, 11, 24'h555555, 24'hAAAAAA, -3, 1, 0, 0,
			0));
		send_pair(make_pair(1, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		send_pair(make_pair(0, 0, 0, 0, 1, 0, 1, 0, 1, 32'h00010002));

		// Random traffic over a range of box settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(BoxW'($urandom_range(1, 24'h3FFFF)),
					BoxW'($urandom_range(1, 24'h3FFFF)), StepW'($urandom));
				1: configure(PosMax, PosMax, {StepW{1'b1}});
				2: configure(1, BoxW'($urandom_range(1, 255)),
					StepW'($urandom_range(0, 255)));
				3: configure(BoxW'($urandom_range(1, 24'hFFFFFF)),
					BoxW'($urandom_range(1, 24'hFFFFFF)), StepW'($urandom));
				4: configure(0, 0, StepW'($urandom));
				default: configure(BoxW'($urandom_range(1, 24'hFFFF)),
					BoxW'($urandom_range(1, 24'hFFFF)), StepW'($urandom));
			endcase
			steady = (ph == 1);
			random_phase(PhaseItems, (ph == 2) ? 140 : PhaseItems + 1);
			steady = 1'b0;
		end

		// Close the open frame, then an empty frame, after which nothing may come out
		repeat (2) begin
			p = random_pair();
			p.usable = 1'b0;
			p.last = 1'b1;
			send_pair(p);
		end
		repeat (20) send_pair(random_pair());

		hold_sender();
		repeat (EndCycles) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending_frames.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
